// ----- hw/rtl/size_class_slab_allocator_top_macros.svh -----
// Assertion macros shared by the slab allocator RTL.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_TOP_MACROS_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCSA_ASSERT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCSA_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/scsa_pkg.sv -----
// Package for the size class slab allocator: status codes, sequencer states,
// page record layout and the slot count table. It depends on nothing else.
`default_nettype none
package scsa_pkg;

   localparam int PAGE_BYTES = 4096;
   localparam int MAX_SLOTS  = 512;
   localparam int PAGE_HDR   = 36;
   localparam int SLOT_HDR   = 8;
   localparam int MAX_REQ    = 1024;
   localparam int CLS_W      = 4;
   localparam int SLOT_W     = 9;
   localparam int TOP_W      = 10;
   localparam int ADDR_W     = 18;

   // A stack top with bit 9 set is the empty stack.
   localparam logic [TOP_W-1:0] SLOT_NULL = 10'd512;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_ZERO      = 3'd1,
      STAT_TOO_LARGE = 3'd2,
      STAT_EXHAUSTED = 3'd3,
      STAT_BAD_FREE  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FCHK,
      ST_WCHK,
      ST_NEW,
      ST_POP,
      ST_POPL,
      ST_POPW,
      ST_ADDR,
      ST_FIX1_RD,
      ST_FIX1_WR,
      ST_FIX2_RD,
      ST_FIX2_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [CLS_W-1:0]  cls;
      logic [SLOT_W-1:0] free_cnt;
      logic [SLOT_W-1:0] untouched;
      logic [TOP_W-1:0]  top;
   } meta_type;

   typedef struct packed {
      status_type        status;
      logic [CLS_W-1:0]  cls;
   } dec_type;

   typedef struct packed {
      logic              mode;
      logic [15:0]       request_size;
      logic [5:0]        free_page;
      logic [8:0]        free_slot;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [5:0]        granted_page;
      logic [8:0]        granted_slot;
      logic [17:0]       granted_address;
   } rsp_type;

   // Slots per page: (4096 - 36) / (8 + (2 << c)), never above 512.
   function automatic logic [SLOT_W-1:0] class_slots(input logic [CLS_W-1:0] c);
      logic [SLOT_W-1:0] n;
      case (c)
         4'd0:    n = 9'd406;
         4'd1:    n = 9'd338;
         4'd2:    n = 9'd253;
         4'd3:    n = 9'd169;
         4'd4:    n = 9'd101;
         4'd5:    n = 9'd56;
         4'd6:    n = 9'd29;
         4'd7:    n = 9'd15;
         4'd8:    n = 9'd7;
         4'd9:    n = 9'd3;
         4'd10:   n = 9'd1;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/scsa_if.sv -----
// Request and response channel interfaces of the slab allocator.
// Both use valid and ready; they depend on nothing else.
`default_nettype none
interface scsa_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [15:0] request_size;
   logic [5:0]  free_page;
   logic [8:0]  free_slot;
   modport source (output valid, mode, request_size, free_page, free_slot, input ready);
   modport sink (input valid, mode, request_size, free_page, free_slot, output ready);
endinterface

interface scsa_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [5:0]  granted_page;
   logic [8:0]  granted_slot;
   logic [17:0] granted_address;
   modport source (output valid, status, granted_page, granted_slot, granted_address,
                   input ready);
   modport sink (input valid, status, granted_page, granted_slot, granted_address,
                 output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/size_class_slab_allocator_top.sv -----
// Slab allocator with power-of-two size classes: page records and slot links in memories.
// Depends on scsa_pkg, scsa_if, scsa_size_decode and the assertion macro header.
//
// Usage. Requests arrive on req_ch: mode 0 allocates request_size bytes, mode 1 frees
// the block named by free_page and free_slot. Each request yields exactly one response
// on rsp_ch with a status and, for a successful allocation, the page, slot and byte
// address of the block. The block works on one request at a time; req_ch.ready is high
// only while the sequencer is idle, and a new request is taken while the previous
// response still waits in the output register.
// Order of work: a request refused on its size or on an idle page goes straight to the
// final state. An allocation examines the pages on its class list in turn, takes a fresh
// page from the pool when none has a free slot (or reports the pool exhausted), pops a
// stacked slot or takes an untouched one, writes the page record back, forms the byte
// address and, when a fresh page is linked in front of an existing one, patches that
// page's back link. A free reads and checks the page record, refusing a bad record, then
// writes the slot link and the record and, when the page is released, patches the link of
// each neighbour. The next request is taken only once the sequencer is idle again.
// Reset clears the page busy bits, empties every class list and drops any pending
// response. When the receiver stalls, the finished response is held and the sequencer
// waits in its final state until the output register is free.
`default_nettype none
`include "size_class_slab_allocator_top_macros.svh"
module size_class_slab_allocator_top #(
   parameter int NUM_PAGES   = 64,
   parameter int NUM_CLASSES = 10
) (
   input wire logic  clock,
   input wire logic  reset,
   scsa_req_if.sink   req_ch,
   scsa_rsp_if.source rsp_ch
);

   localparam int PIW = $clog2(NUM_PAGES);
   localparam int PNW = $clog2(NUM_PAGES + 1);
   localparam int CIW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int LIW = PIW + scsa_pkg::SLOT_W;
   localparam logic [PNW-1:0] PAGE_NULL = PNW'(NUM_PAGES);

   // A page record: its slot bookkeeping plus its place on the class list.
   typedef struct packed {
      scsa_pkg::meta_type m;
      logic [PNW-1:0]     nxt;
      logic [PNW-1:0]     prv;
   } entry_type;

   typedef struct packed {
      logic           vld;
      logic [PNW-1:0] addr;
      logic [PNW-1:0] val;
   } fix_type;

   // Memories.
   entry_type meta_mem [NUM_PAGES];
   logic [scsa_pkg::TOP_W-1:0] link_mem [NUM_PAGES * scsa_pkg::MAX_SLOTS];
   entry_type meta_q;
   logic [scsa_pkg::TOP_W-1:0] link_q;
   logic meta_we, meta_re, link_we, link_re;
   logic [PIW-1:0] meta_wa, meta_ra;
   logic [LIW-1:0] link_wa, link_ra;
   entry_type meta_wd;
   logic [scsa_pkg::TOP_W-1:0] link_wd;

   // Control and working registers.
   scsa_pkg::state_type state_ff, state_in;
   logic [NUM_PAGES-1:0] busy_ff, busy_in;
   logic [PNW-1:0] head_ff [NUM_CLASSES];
   logic [PNW-1:0] head_in [NUM_CLASSES];
   logic [PNW-1:0] idle_ff, idle_in;
   logic [PNW-1:0] steps_ff, steps_in;
   logic rsp_valid_ff, rsp_valid_in;
   scsa_pkg::rsp_type rsp_ff, rsp_in;
   logic mode_ff, mode_in;
   scsa_pkg::status_type status_ff, status_in;
   logic [scsa_pkg::CLS_W-1:0] cls_ff, cls_in;
   logic [PIW-1:0] page_ff, page_in;
   logic [scsa_pkg::SLOT_W-1:0] slot_ff, slot_in;
   entry_type ent_ff, ent_in;
   fix_type fix1_ff, fix1_in, fix2_ff, fix2_in;
   logic [19:0] prod_ff, prod_in;
   logic [scsa_pkg::ADDR_W-1:0] addr_ff, addr_in;

   scsa_pkg::dec_type dec;
   logic [scsa_pkg::SLOT_W-1:0] total;
   logic [10:0] stride;
   logic req_page_ok;

   scsa_size_decode #(.NUM_CLASSES(NUM_CLASSES)) u_dec (
      .request_size (req_ch.request_size),
      .dec          (dec)
   );

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      if (meta_re) begin
         meta_q <= meta_mem[meta_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (link_re) begin
         link_q <= link_mem[link_ra];
      end
   end

   // The lowest idle page is registered from the busy bits; busy bits change only in states
   // of a request that are never directly followed by the state taking a page from the pool.
   always_comb begin
      idle_in = PAGE_NULL;
      for (int i = NUM_PAGES - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            idle_in = PNW'(i);
         end
      end
   end

   assign req_ch.ready = (state_ff == scsa_pkg::ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_ff.status;
   assign rsp_ch.granted_page = rsp_ff.granted_page;
   assign rsp_ch.granted_slot = rsp_ff.granted_slot;
   assign rsp_ch.granted_address = rsp_ff.granted_address;

   assign req_page_ok = ({26'd0, req_ch.free_page} < 32'(NUM_PAGES))
                        && busy_ff[PIW'(req_ch.free_page)];
   assign total = scsa_pkg::class_slots(meta_q.m.cls);
   assign stride = 11'(scsa_pkg::SLOT_HDR) + (11'd2 << cls_ff);

   always_comb begin
      state_in = state_ff;
      busy_in = busy_ff;
      head_in = head_ff;
      steps_in = steps_ff;
      mode_in = mode_ff;
      status_in = status_ff;
      cls_in = cls_ff;
      page_in = page_ff;
      slot_in = slot_ff;
      ent_in = ent_ff;
      fix1_in = fix1_ff;
      fix2_in = fix2_ff;
      prod_in = prod_ff;
      addr_in = addr_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      meta_we = 1'b0;
      meta_re = 1'b0;
      meta_wa = page_ff;
      meta_ra = page_ff;
      meta_wd = ent_ff;
      link_we = 1'b0;
      link_re = 1'b0;
      link_wa = {page_ff, slot_ff};
      link_ra = {page_ff, ent_ff.m.top[scsa_pkg::SLOT_W-1:0]};
      link_wd = ent_ff.m.top;

      case (state_ff)
         scsa_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               mode_in = req_ch.mode;
               fix1_in = '0;
               fix2_in = '0;
               steps_in = '0;
               status_in = scsa_pkg::STAT_OK;
               if (req_ch.mode) begin
                  page_in = PIW'(req_ch.free_page);
                  slot_in = req_ch.free_slot;
                  if (req_page_ok) begin
                     meta_re = 1'b1;
                     meta_ra = PIW'(req_ch.free_page);
                     state_in = scsa_pkg::ST_FCHK;
                  end else begin
                     status_in = scsa_pkg::STAT_BAD_FREE;
                     state_in = scsa_pkg::ST_DONE;
                  end
               end else begin
                  cls_in = dec.cls;
                  if (dec.status != scsa_pkg::STAT_OK) begin
                     status_in = dec.status;
                     state_in = scsa_pkg::ST_DONE;
                  end else if (head_ff[dec.cls[CIW-1:0]] == PAGE_NULL) begin
                     state_in = scsa_pkg::ST_NEW;
                  end else begin
                     meta_re = 1'b1;
                     meta_ra = head_ff[dec.cls[CIW-1:0]][PIW-1:0];
                     page_in = head_ff[dec.cls[CIW-1:0]][PIW-1:0];
                     state_in = scsa_pkg::ST_WCHK;
                  end
               end
            end
         end

         scsa_pkg::ST_WCHK: begin
            steps_in = steps_ff + PNW'(1);
            if (meta_q.m.free_cnt != '0) begin
               ent_in = meta_q;
               state_in = scsa_pkg::ST_POP;
            end else if (meta_q.nxt == PAGE_NULL
                         || steps_ff + PNW'(1) >= PNW'(NUM_PAGES)) begin
               state_in = scsa_pkg::ST_NEW;
            end else begin
               meta_re = 1'b1;
               meta_ra = meta_q.nxt[PIW-1:0];
               page_in = meta_q.nxt[PIW-1:0];
            end
         end

         scsa_pkg::ST_NEW: begin
            if (idle_ff == PAGE_NULL) begin
               status_in = scsa_pkg::STAT_EXHAUSTED;
               state_in = scsa_pkg::ST_DONE;
            end else begin
               page_in = idle_ff[PIW-1:0];
               busy_in[idle_ff[PIW-1:0]] = 1'b1;
               ent_in.m.cls = cls_ff;
               ent_in.m.free_cnt = scsa_pkg::class_slots(cls_ff);
               ent_in.m.untouched = '0;
               ent_in.m.top = scsa_pkg::SLOT_NULL;
               ent_in.nxt = head_ff[cls_ff[CIW-1:0]];
               ent_in.prv = PAGE_NULL;
               head_in[cls_ff[CIW-1:0]] = idle_ff;
               // The old head, if any, now points back at the new page.
               fix2_in.vld = (head_ff[cls_ff[CIW-1:0]] != PAGE_NULL);
               fix2_in.addr = head_ff[cls_ff[CIW-1:0]];
               fix2_in.val = idle_ff;
               state_in = scsa_pkg::ST_POP;
            end
         end

         scsa_pkg::ST_POP: begin
            ent_in.m.free_cnt = ent_ff.m.free_cnt - scsa_pkg::SLOT_W'(1);
            if (!ent_ff.m.top[scsa_pkg::TOP_W-1]) begin
               link_re = 1'b1;
               state_in = scsa_pkg::ST_POPL;
            end else begin
               slot_in = ent_ff.m.untouched;
               ent_in.m.untouched = ent_ff.m.untouched + scsa_pkg::SLOT_W'(1);
               state_in = scsa_pkg::ST_POPW;
            end
         end

         scsa_pkg::ST_POPL: begin
            slot_in = ent_ff.m.top[scsa_pkg::SLOT_W-1:0];
            ent_in.m.top = link_q;
            state_in = scsa_pkg::ST_POPW;
         end

         scsa_pkg::ST_POPW: begin
            meta_we = 1'b1;
            prod_in = 20'(slot_ff) * 20'(stride);
            state_in = scsa_pkg::ST_ADDR;
         end

         scsa_pkg::ST_ADDR: begin
            addr_in = {6'(page_ff), 12'd0}
                      + 18'(scsa_pkg::PAGE_HDR + scsa_pkg::SLOT_HDR) + prod_ff[17:0];
            if (fix1_ff.vld) begin
               state_in = scsa_pkg::ST_FIX1_RD;
            end else if (fix2_ff.vld) begin
               state_in = scsa_pkg::ST_FIX2_RD;
            end else begin
               state_in = scsa_pkg::ST_DONE;
            end
         end

         scsa_pkg::ST_FCHK: begin
            if (32'(meta_q.m.cls) >= NUM_CLASSES || slot_ff >= meta_q.m.untouched
                || meta_q.m.free_cnt >= total) begin
               status_in = scsa_pkg::STAT_BAD_FREE;
               state_in = scsa_pkg::ST_DONE;
            end else begin
               link_we = 1'b1;
               link_wd = meta_q.m.top;
               meta_we = 1'b1;
               meta_wd = meta_q;
               meta_wd.m.top = {1'b0, slot_ff};
               meta_wd.m.free_cnt = meta_q.m.free_cnt + scsa_pkg::SLOT_W'(1);
               state_in = scsa_pkg::ST_DONE;
               if (meta_q.m.free_cnt + scsa_pkg::SLOT_W'(1) == total) begin
                  // The page is empty again: unlink it and hand it back to the pool.
                  busy_in[page_ff] = 1'b0;
                  fix1_in.vld = (meta_q.prv != PAGE_NULL);
                  fix1_in.addr = meta_q.prv;
                  fix1_in.val = meta_q.nxt;
                  fix2_in.vld = (meta_q.nxt != PAGE_NULL);
                  fix2_in.addr = meta_q.nxt;
                  fix2_in.val = meta_q.prv;
                  if (meta_q.prv == PAGE_NULL) begin
                     head_in[meta_q.m.cls[CIW-1:0]] = meta_q.nxt;
                  end
                  if (meta_q.prv != PAGE_NULL) begin
                     state_in = scsa_pkg::ST_FIX1_RD;
                  end else if (meta_q.nxt != PAGE_NULL) begin
                     state_in = scsa_pkg::ST_FIX2_RD;
                  end
               end
            end
         end

         scsa_pkg::ST_FIX1_RD: begin
            meta_re = 1'b1;
            meta_ra = fix1_ff.addr[PIW-1:0];
            state_in = scsa_pkg::ST_FIX1_WR;
         end

         scsa_pkg::ST_FIX1_WR: begin
            meta_we = 1'b1;
            meta_wa = fix1_ff.addr[PIW-1:0];
            meta_wd = meta_q;
            meta_wd.nxt = fix1_ff.val;
            state_in = fix2_ff.vld ? scsa_pkg::ST_FIX2_RD : scsa_pkg::ST_DONE;
         end

         scsa_pkg::ST_FIX2_RD: begin
            meta_re = 1'b1;
            meta_ra = fix2_ff.addr[PIW-1:0];
            state_in = scsa_pkg::ST_FIX2_WR;
         end

         scsa_pkg::ST_FIX2_WR: begin
            meta_we = 1'b1;
            meta_wa = fix2_ff.addr[PIW-1:0];
            meta_wd = meta_q;
            meta_wd.prv = fix2_ff.val;
            state_in = scsa_pkg::ST_DONE;
         end

         scsa_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = status_ff;
               if (!mode_ff && status_ff == scsa_pkg::STAT_OK) begin
                  rsp_in.granted_page = 6'(page_ff);
                  rsp_in.granted_slot = slot_ff;
                  rsp_in.granted_address = addr_ff;
               end else begin
                  rsp_in.granted_page = '0;
                  rsp_in.granted_slot = '0;
                  rsp_in.granted_address = '0;
               end
               state_in = scsa_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = scsa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scsa_pkg::ST_IDLE;
         busy_ff <= '0;
         rsp_valid_ff <= 1'b0;
         idle_ff <= '0;
         steps_ff <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i] <= PAGE_NULL;
         end
      end else begin
         state_ff <= state_in;
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         idle_ff <= idle_in;
         steps_ff <= steps_in;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      status_ff <= status_in;
      cls_ff <= cls_in;
      page_ff <= page_in;
      slot_ff <= slot_in;
      ent_ff <= ent_in;
      fix1_ff <= fix1_in;
      fix2_ff <= fix2_in;
      prod_ff <= prod_in;
      addr_ff <= addr_in;
      rsp_ff <= rsp_in;
   end

   `SCSA_ASSERT_NEXT(a_busy_after_accept, req_ch.valid && req_ch.ready, state_ff != scsa_pkg::ST_IDLE, "sequencer idle after accepting a request")
   `SCSA_ASSERT(a_walk_bound, state_ff == scsa_pkg::ST_WCHK, steps_ff < PNW'(NUM_PAGES), "class list walk ran past the page count")
   `SCSA_ASSERT_NEXT(a_done_loads, state_ff == scsa_pkg::ST_DONE && (!rsp_valid_ff || rsp_ch.ready), rsp_valid_ff, "finished request produced no response")
   `SCSA_ASSERT(a_new_page_idle, state_ff == scsa_pkg::ST_NEW && idle_ff != PAGE_NULL, !busy_ff[idle_ff[PIW-1:0]], "page taken from the pool is already busy")

endmodule
`default_nettype wire

// ----- hw/rtl/scsa_size_decode.sv -----
// Size decoder: maps a request size to its power-of-two class or an error status.
// Depends on scsa_pkg.
`default_nettype none
module scsa_size_decode #(
   parameter int NUM_CLASSES = 10
) (
   input  wire logic [15:0]        request_size,
   output scsa_pkg::dec_type       dec
);

   logic [15:0] less_one;
   logic [scsa_pkg::CLS_W-1:0] cls;

   always_comb begin
      less_one = request_size - 16'd1;
      cls = '0;
      // The class is the index of the top set bit of size minus one.
      for (int i = 1; i < 10; i++) begin
         if (less_one[i]) begin
            cls = scsa_pkg::CLS_W'(i);
         end
      end
      dec.cls = cls;
      if (request_size == 16'd0) begin
         dec.status = scsa_pkg::STAT_ZERO;
      end else if (request_size > 16'(scsa_pkg::MAX_REQ)) begin
         dec.status = scsa_pkg::STAT_TOO_LARGE;
      end else if (32'(cls) >= NUM_CLASSES) begin
         dec.status = scsa_pkg::STAT_TOO_LARGE;
      end else begin
         dec.status = scsa_pkg::STAT_OK;
      end
   end

endmodule
`default_nettype wire

// ----- tb/tb_size_class_slab_allocator_top.sv -----
// Self-checking testbench for the size class slab allocator: allocate and free requests
// are predicted by a behavioural page and slot model. Depends on scsa_pkg, scsa_if, RTL.
`default_nettype none
module tb_size_class_slab_allocator_top;

   localparam int NP        = 64;
   localparam int NCLS      = 10;
   localparam int LIMIT     = 1000000;
   localparam int RAND_REQS = 1230;

   logic clock = 1'b0;
   logic reset;

   scsa_req_if req_ch ();
   scsa_rsp_if rsp_ch ();

   size_class_slab_allocator_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the allocator state. Entries that the block leaves undefined are only
   // read here after the request stream has written them, as in the block itself.
   bit page_used [NP];
   int page_cls [NP];
   int page_avail [NP];
   int page_fresh [NP];
   int page_top [NP];
   int page_next [NP];
   int page_prev [NP];
   int slot_link [NP*scsa_pkg::MAX_SLOTS];
   int cls_head [NCLS];

   scsa_pkg::req_type pending_requests[$];
   scsa_pkg::rsp_type grant_expect[$];
   // Handles of blocks currently handed out, as page * 512 + slot.
   int live_blocks[$];

   int  cycle_count = 0;
   int  responses_seen = 0;
   bit  failed = 1'b0;

   function automatic int slots_for_class(int c);
      return (scsa_pkg::PAGE_BYTES - scsa_pkg::PAGE_HDR) / (scsa_pkg::SLOT_HDR + (2 << c));
   endfunction

   // Works out the response to one request and advances the shadow state.
   function automatic scsa_pkg::rsp_type serve_request(scsa_pkg::req_type r);
      scsa_pkg::rsp_type o;
      int c, cs, p, steps, slot, h, total, nx, pv;
      o = '0;
      if (!r.mode) begin
         if (r.request_size == 0) begin
            o.status = scsa_pkg::STAT_ZERO;
         end else if (r.request_size > scsa_pkg::MAX_REQ) begin
            o.status = scsa_pkg::STAT_TOO_LARGE;
         end else begin
            c  = 0;
            cs = 2;
            while (cs < r.request_size) begin
               cs = cs << 1;
               c++;
            end
            p = cls_head[c];
            steps = 0;
            while (p < NP && steps < NP && page_avail[p] == 0) begin
               p = page_next[p];
               steps++;
            end
            if (p >= NP || steps >= NP) begin
               h = cls_head[c];
               p = 0;
               while (p < NP && page_used[p]) p++;
               if (p >= NP) begin
                  o.status = scsa_pkg::STAT_EXHAUSTED;
               end else begin
                  page_used[p]  = 1'b1;
                  page_cls[p]   = c;
                  page_avail[p] = slots_for_class(c);
                  page_fresh[p] = 0;
                  page_top[p]   = scsa_pkg::MAX_SLOTS;
                  page_next[p]  = h;
                  page_prev[p]  = NP;
                  if (h < NP) page_prev[h] = p;
                  cls_head[c] = p;
               end
            end
            if (o.status == scsa_pkg::STAT_OK) begin
               if (page_top[p] < scsa_pkg::MAX_SLOTS) begin
                  slot = page_top[p];
                  page_top[p] = slot_link[p*scsa_pkg::MAX_SLOTS + slot];
               end else begin
                  slot = page_fresh[p] % scsa_pkg::MAX_SLOTS;
                  page_fresh[p]++;
               end
               page_avail[p]--;
               o.granted_page    = 6'(p);
               o.granted_slot    = 9'(slot);
               o.granted_address = 18'(p*scsa_pkg::PAGE_BYTES + scsa_pkg::PAGE_HDR
                                       + slot*(scsa_pkg::SLOT_HDR + cs) + scsa_pkg::SLOT_HDR);
            end
         end
      end else begin
         p    = int'(r.free_page);
         slot = int'(r.free_slot);
         if (!page_used[p]) begin
            o.status = scsa_pkg::STAT_BAD_FREE;
         end else begin
            c = page_cls[p];
            total = slots_for_class(c);
            if (slot >= page_fresh[p] || page_avail[p] >= total) begin
               o.status = scsa_pkg::STAT_BAD_FREE;
            end else begin
               slot_link[p*scsa_pkg::MAX_SLOTS + slot] = page_top[p];
               page_top[p] = slot;
               page_avail[p]++;
               if (page_avail[p] == total) begin
                  nx = page_next[p];
                  pv = page_prev[p];
                  if (pv < NP) page_next[pv] = nx;
                  else cls_head[c] = nx;
                  if (nx < NP) page_prev[nx] = pv;
                  page_used[p] = 1'b0;
               end
            end
         end
      end
      return o;
   endfunction

   // Queues one request and its predicted response, and keeps the list of live blocks.
   task automatic issue_request(bit mode, int size, int page, int slot);
      scsa_pkg::req_type r;
      scsa_pkg::rsp_type o;
      r.mode         = mode;
      r.request_size = 16'(size);
      r.free_page    = 6'(page);
      r.free_slot    = 9'(slot);
      o = serve_request(r);
      if (!mode && o.status == scsa_pkg::STAT_OK)
         live_blocks.push_back(int'(o.granted_page)*scsa_pkg::MAX_SLOTS
                               + int'(o.granted_slot));
      pending_requests.push_back(r);
      grant_expect.push_back(o);
   endtask

   // Frees a live block; now and then it stays listed so that a double free follows.
   task automatic free_live_block();
      int k, h;
      k = $urandom_range(0, live_blocks.size() - 1);
      h = live_blocks[k];
      if ($urandom_range(0, 29) != 0) live_blocks.delete(k);
      issue_request(1'b1, 0, h / scsa_pkg::MAX_SLOTS, h % scsa_pkg::MAX_SLOTS);
   endtask

   function automatic int pick_size(int kind);
      case (kind)
         0: return $urandom_range(1, 64);
         1: return $urandom_range(1, scsa_pkg::MAX_REQ);
         2: return $urandom_range(513, scsa_pkg::MAX_REQ);
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // Request source: bursts of random length with random gaps in between. The payload is
   // held whilst the block is not ready, so a request is never withdrawn.
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left   <= 1;
         gap_left     <= 0;
      end else if (req_ch.valid && !req_ch.ready) begin
         // The current request waits for acceptance.
      end else if (gap_left > 0) begin
         gap_left     <= gap_left - 1;
         req_ch.valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
         req_ch.valid        <= 1'b1;
         req_ch.mode         <= pending_requests[0].mode;
         req_ch.request_size <= pending_requests[0].request_size;
         req_ch.free_page    <= pending_requests[0].free_page;
         req_ch.free_slot    <= pending_requests[0].free_slot;
         void'(pending_requests.pop_front());
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // Response sink: a random stall pattern whose density is redrawn periodically, with
   // stretches of no stalls at all. Once, a long hold-off lets the block fill and stall
   // its input whilst the source keeps offering requests.
   int  hold_left;
   bit  hold_done;
   int  stall_pct;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
         hold_done    <= 1'b0;
         stall_pct    <= 0;
      end else begin
         if (cycle_count % 128 == 0) stall_pct <= $urandom_range(0, 3) * 20;
         if (!hold_done && responses_seen == 300) begin
            hold_done    <= 1'b1;
            hold_left    <= 400;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Checks each accepted response against the oldest prediction, field by field.
   always @(posedge clock) begin
      scsa_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         responses_seen <= responses_seen + 1;
         if (grant_expect.size() == 0) begin
            $error("response with nothing expected: status %0d", rsp_ch.status);
            failed <= 1'b1;
         end else begin
            want = grant_expect.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               failed <= 1'b1;
            end
            if (rsp_ch.granted_page !== want.granted_page) begin
               $error("granted_page: expected %0d, got %0d",
                      want.granted_page, rsp_ch.granted_page);
               failed <= 1'b1;
            end
            if (rsp_ch.granted_slot !== want.granted_slot) begin
               $error("granted_slot: expected %0d, got %0d",
                      want.granted_slot, rsp_ch.granted_slot);
               failed <= 1'b1;
            end
            if (rsp_ch.granted_address !== want.granted_address) begin
               $error("granted_address: expected %0d, got %0d",
                      want.granted_address, rsp_ch.granted_address);
               failed <= 1'b1;
            end
         end
      end
   end

   // The run is cut short if it goes on far longer than any correct run could.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("[size_class_slab_allocator_top] ERROR");
         $finish;
      end
   end

   initial begin
      int n, seg_left, alloc_pct, size_kind;
      reset          = 1'b1;
      for (int i = 0; i < NP; i++) page_used[i] = 1'b0;
      for (int i = 0; i < NCLS; i++) cls_head[i] = NP;

      // Directed part: size extremes, every class boundary worth a look, and the
      // failing frees (idle page, slot never handed out, page already all free).
      issue_request(1'b0, 0, 0, 0);
      issue_request(1'b0, 1, 0, 0);
      issue_request(1'b0, 2, 0, 0);
      issue_request(1'b0, 3, 0, 0);
      issue_request(1'b0, scsa_pkg::MAX_REQ, 0, 0);
      issue_request(1'b0, scsa_pkg::MAX_REQ + 1, 0, 0);
      issue_request(1'b0, 65535, 0, 0);
      issue_request(1'b0, 512, 0, 0);
      issue_request(1'b1, 0, 63, 511);
      issue_request(1'b1, 0, 0, 400);
      issue_request(1'b1, 0, 0, 0);
      issue_request(1'b0, 1, 0, 0);
      issue_request(1'b1, 0, 0, 1);
      issue_request(1'b1, 0, 0, 1);
      issue_request(1'b0, 1, 0, 0);
      issue_request(1'b0, 1000, 0, 0);
      issue_request(1'b0, 1000, 0, 0);
      issue_request(1'b0, 1000, 0, 0);
      issue_request(1'b1, 0, 2, 1);
      issue_request(1'b1, 0, 2, 0);
      issue_request(1'b1, 0, 2, 2);
      issue_request(1'b1, 0, 2, 2);
      live_blocks.delete();
      for (int p = 0; p < NP; p++)
         if (page_used[p])
            for (int s = 0; s < page_fresh[p]; s++)
               live_blocks.push_back(p*scsa_pkg::MAX_SLOTS + s);

      // Random part in segments with their own mix. One segment opens with a flood of the
      // largest class so that the pool runs dry, followed by a run of frees that drains it again.
      n = 0;
      seg_left = 0;
      alloc_pct = 50;
      size_kind = 1;
      while (n < RAND_REQS) begin
         if (seg_left == 0) begin
            seg_left  = $urandom_range(30, 80);
            alloc_pct = ($urandom_range(0, 2) == 0) ? 80 : (($urandom_range(0, 1)) ? 50 : 25);
            size_kind = $urandom_range(0, 2);
            if (n > 500 && n < 600) begin
               for (int k = 0; k < 210; k++) issue_request(1'b0, pick_size(2), 0, 0);
               for (int k = 0; k < 200 && live_blocks.size() > 0; k++) free_live_block();
               n += 410;
            end
         end
         if ($urandom_range(0, 19) == 0) begin
            // Noise: any size, or a free of an arbitrary handle.
            issue_request(1'($urandom_range(0, 1)), pick_size(3),
                          $urandom_range(0, NP - 1),
                          $urandom_range(0, scsa_pkg::MAX_SLOTS - 1));
         end else if ($urandom_range(0, 99) < alloc_pct || live_blocks.size() == 0) begin
            issue_request(1'b0, pick_size(size_kind), 0, 0);
         end else begin
            free_live_block();
         end
         n++;
         seg_left--;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (pending_requests.size() == 0 && grant_expect.size() == 0);
      repeat (200) @(posedge clock);
      if (!failed && grant_expect.size() == 0) begin
         $display("[size_class_slab_allocator_top] OK");
      end else begin
         $display("[size_class_slab_allocator_top] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/scsa_pkg.sv
hw/rtl/scsa_if.sv
hw/rtl/scsa_size_decode.sv
hw/rtl/size_class_slab_allocator_top.sv
tb/tb_size_class_slab_allocator_top.sv
